// File: rtl/core/rpt_pkg.sv
// Shared constants and types for the rigid point transform
package rpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_MAX_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0 = 3'd0,
        CFG_ROT_ROW1 = 3'd1,
        CFG_ROT_ROW2 = 3'd2,
        CFG_TRANS_X  = 3'd3,
        CFG_TRANS_Y  = 3'd4,
        CFG_TRANS_Z  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic vld;
        logic last;
    } t_tag;

endpackage

// File: rtl/core/rpt_mul.sv
// Stage 1: nine coefficient by coordinate products
module rpt_mul import rpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    localparam int PW         = COORD_WIDTH + COEF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  t_tag                          i_tag,
    input  logic signed [COORD_WIDTH-1:0] i_pt [3],
    input  logic [3*COEF_WIDTH-1:0]       i_row [3],
    output t_tag                          o_tag,
    output logic signed [PW-1:0]          o_prod [3][3]
);

    t_tag                 r_tag;
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [PW-1:0] n_prod [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = PW'($signed(i_row[r][c*COEF_WIDTH +: COEF_WIDTH]))
                             * PW'(i_pt[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_ce) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= n_prod;
        end
    end

    assign o_tag  = r_tag;
    assign o_prod = r_prod;

endmodule

// File: rtl/core/rpt_rnd.sv
// Stage 2: round products and form two partial sums per row
module rpt_rnd import rpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    localparam int PW         = COORD_WIDTH + COEF_WIDTH,
    localparam int FRAC       = COEF_WIDTH - 2,
    localparam int RW         = PW - FRAC,
    localparam int SW         = COORD_WIDTH + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  t_tag                          i_tag,
    input  logic signed [PW-1:0]          i_prod [3][3],
    input  logic signed [COORD_WIDTH-1:0] i_trans [3],
    output t_tag                          o_tag,
    output logic signed [SW-1:0]          o_pa [3],
    output logic signed [SW-1:0]          o_pb [3]
);

    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC - 1);

    t_tag                 r_tag;
    logic signed [SW-1:0] r_pa [3];
    logic signed [SW-1:0] r_pb [3];
    logic signed [SW-1:0] n_pa [3];
    logic signed [SW-1:0] n_pb [3];
    logic signed [PW-1:0] biased [3][3];
    logic signed [RW-1:0] rnd [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                biased[r][c] = i_prod[r][c] + HALF;
                rnd[r][c]    = $signed(biased[r][c][PW-1:FRAC]);
            end
            n_pa[r] = SW'(rnd[r][0]) + SW'(rnd[r][1]);
            n_pb[r] = SW'(rnd[r][2]) + SW'(i_trans[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_ce) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
    end

    assign o_tag = r_tag;
    assign o_pa  = r_pa;
    assign o_pb  = r_pb;

endmodule

// File: rtl/core/rpt_sat.sv
// Stage 3: final sum, saturation and output register
module rpt_sat import rpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int SW         = COORD_WIDTH + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  t_tag                          i_tag,
    input  logic signed [SW-1:0]          i_pa [3],
    input  logic signed [SW-1:0]          i_pb [3],
    output t_tag                          o_tag,
    output logic signed [COORD_WIDTH-1:0] o_res [3],
    output logic                          o_sat
);

    localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    t_tag                          r_tag;
    logic signed [COORD_WIDTH-1:0] r_res [3];
    logic                          r_sat;
    logic signed [COORD_WIDTH-1:0] n_res [3];
    logic                          n_sat;
    logic signed [SW-1:0]          sum [3];
    logic [2:0]                    ovf;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = i_pa[r] + i_pb[r];
            ovf[r] = (sum[r][SW-1:COORD_WIDTH-1] != '0)
                  && (sum[r][SW-1:COORD_WIDTH-1] != '1);
            if (!ovf[r]) begin
                n_res[r] = sum[r][COORD_WIDTH-1:0];
            end else if (sum[r][SW-1]) begin
                n_res[r] = MINV;
            end else begin
                n_res[r] = MAXV;
            end
        end
        n_sat = |ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_ce) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_tag = r_tag;
    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

// File: rtl/core/rigid_point_transform_top.sv
// Pipeline: 3 register stages, multiply, round and saturate.
// Throughput: one point per cycle while the output is not stalled by i_res_stall.
// Each stage holds its word while the next is full and stalled; bubbles are squeezed out.
// Reset clears all stage valids and loads the identity rotation with zero translation.
// Configuration is always ready; writes to unused indexes are dropped.
module rigid_point_transform_top import rpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    localparam int ROW_W      = (3 * COEF_WIDTH > CFG_DATA_MAX_W) ? CFG_DATA_MAX_W
                                                                 : 3 * COEF_WIDTH,
    localparam int DATA_W     = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [DATA_W-1:0]             i_cfg_data,
    input  logic                          i_pt_valid,
    output logic                          o_pt_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pt_x,
    input  logic signed [COORD_WIDTH-1:0] i_pt_y,
    input  logic signed [COORD_WIDTH-1:0] i_pt_z,
    input  logic                          i_last_point,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic signed [COORD_WIDTH-1:0] o_res_x,
    output logic signed [COORD_WIDTH-1:0] o_res_y,
    output logic signed [COORD_WIDTH-1:0] o_res_z,
    output logic                          o_saturated,
    output logic                          o_last_out
);

    localparam int CW3 = 3 * COEF_WIDTH;
    localparam int PW  = COORD_WIDTH + COEF_WIDTH;
    localparam int SW  = COORD_WIDTH + 4;
    localparam logic [CW3-1:0] ID0 = CW3'(1) << (COEF_WIDTH - 2);
    localparam logic [CW3-1:0] ID1 = ID0 << COEF_WIDTH;
    localparam logic [CW3-1:0] ID2 = ID1 << COEF_WIDTH;

    logic [ROW_W-1:0]              r_rot [3];
    logic signed [COORD_WIDTH-1:0] r_trans [3];
    logic [CW3-1:0]                row_ext [3];
    logic signed [COORD_WIDTH-1:0] pt [3];
    logic                          mv1, mv2, mv3;
    t_tag                          in_tag, tag1, tag2, tag3;
    logic signed [PW-1:0]          prod [3][3];
    logic signed [SW-1:0]          pa [3];
    logic signed [SW-1:0]          pb [3];
    logic signed [COORD_WIDTH-1:0] res [3];
    logic                          sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROW_W'(ID0);
            r_rot[1]   <= ROW_W'(ID1);
            r_rot[2]   <= ROW_W'(ID2);
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROT_ROW0: r_rot[0]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW1: r_rot[1]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROT_ROW2: r_rot[2]   <= i_cfg_data[ROW_W-1:0];
                CFG_TRANS_X:  r_trans[0] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_TRANS_Y:  r_trans[1] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_TRANS_Z:  r_trans[2] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_ext[r] = CW3'(r_rot[r]);
        end
    end

    assign mv3        = !tag3.vld || !i_res_stall;
    assign mv2        = !tag2.vld || mv3;
    assign mv1        = !tag1.vld || mv2;
    assign o_pt_stall = !mv1;

    assign in_tag.vld  = i_pt_valid;
    assign in_tag.last = i_last_point;
    assign pt[0]       = i_pt_x;
    assign pt[1]       = i_pt_y;
    assign pt[2]       = i_pt_z;

    rpt_mul #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (mv1),
        .i_tag   (in_tag),
        .i_pt    (pt),
        .i_row   (row_ext),
        .o_tag   (tag1),
        .o_prod  (prod)
    );

    rpt_rnd #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_rnd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (mv2),
        .i_tag   (tag1),
        .i_prod  (prod),
        .i_trans (r_trans),
        .o_tag   (tag2),
        .o_pa    (pa),
        .o_pb    (pb)
    );

    rpt_sat #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (mv3),
        .i_tag   (tag2),
        .i_pa    (pa),
        .i_pb    (pb),
        .o_tag   (tag3),
        .o_res   (res),
        .o_sat   (sat)
    );

    assign o_res_valid = tag3.vld;
    assign o_last_out  = tag3.last;
    assign o_res_x     = res[0];
    assign o_res_y     = res[1];
    assign o_res_z     = res[2];
    assign o_saturated = sat;

endmodule
